@@ hdl/multi_waveform_phase_oscillator_assert.svh @@
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator_assert.svh
// Assertion macros shared by the oscillator checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_ASSERT_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MWPO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MWPO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mwpo_pkg.sv @@
// ----------------------------------------------------------------------------
// mwpo_pkg
// Codes, widths and the sine table builder for the phase oscillator.
// ----------------------------------------------------------------------------
package mwpo_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SINE_DEPTH_DEF  = 1024;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int TIDX_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 32;
  localparam int WAVE_W   = 3;
  localparam int TLEN_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

  // Waveforms
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_CUSTOM   = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LEN = 2'd2;

  // Register reset values
  localparam logic [PHASE_W-1:0] PHASE_INC_RST = 32'd39370534;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Sine of x (Q30 radians, 0..pi/2) as a 15-bit magnitude, Taylor series to x^13.
  // Only called on constants: the table is fixed at elaboration.
  function automatic logic [14:0] sine_q15(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [65:0] sum;
    logic [63:0]        v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed({2'b00, x});
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed({2'b00, term});
    if (sum < 0) begin
      sum = '0;
    end
    v = (sum[63:0] * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

@@ hdl/mwpo_ram.sv @@
// ----------------------------------------------------------------------------
// mwpo_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mwpo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/multi_waveform_phase_oscillator.sv @@
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator
// Phase-accumulator oscillator with sine, square, sawtooth, triangle and
// interpolated custom wavetable outputs in Q1.15.
// ----------------------------------------------------------------------------
// Start, stop and table-write beats finish in the cycle they are accepted and
// the input is ready again on the next cycle. A tick holds the input until
// its sample is taken into the output register. Square, sawtooth, triangle,
// an inactive oscillator, an empty custom table or an unused wave code go
// straight to the output; sine takes one pass of the shared multiplier, then
// one compare-and-subtract of the quarter length per quadrant passed, then
// the registered quarter-wave ROM; the custom table takes two passes of the
// shared multiplier and two reads through the single read port of the
// table RAM. A finished sample waits in the output register; a tick that is
// done while it is still held stalls until it is taken. Configuration writes
// are taken at any cycle and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator #(
  parameter int TABLE_DEPTH = mwpo_pkg::TABLE_DEPTH_DEF,
  parameter int SINE_DEPTH  = mwpo_pkg::SINE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mwpo_pkg::CMD_W-1:0]            in_command,
  input  logic [mwpo_pkg::TIDX_W-1:0]           in_table_index,
  input  logic signed [mwpo_pkg::SAMPLE_W-1:0]  in_table_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mwpo_pkg::SAMPLE_W-1:0]  out_sample,
  // configuration
  input  logic                                  cfg_we,
  input  logic [mwpo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mwpo_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import mwpo_pkg::*;

  // Derived sizes
  localparam int QUARTER = SINE_DEPTH / 4;
  localparam int S_W     = $clog2(QUARTER + 1);
  localparam int RW      = $clog2(4 * QUARTER);
  localparam int N_W     = $clog2(TABLE_DEPTH + 1);
  localparam int TA_W    = $clog2(TABLE_DEPTH);
  localparam int Q4_W    = $clog2(4 * QUARTER + 1);
  localparam int MB_MAX  = (N_W > Q4_W) ? ((N_W > 16) ? N_W : 16) : ((Q4_W > 16) ? Q4_W : 16);
  localparam int MB_W    = MB_MAX + 1;
  localparam int MA_W    = PHASE_W + 1;
  localparam int P_W     = MA_W + MB_W;
  localparam int IW      = P_W - PHASE_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_POS    = 4'd2;
  localparam logic [3:0] S_QUAD   = 4'd3;
  localparam logic [3:0] S_ROM    = 4'd4;
  localparam logic [3:0] S_RD0    = 4'd5;
  localparam logic [3:0] S_RD1    = 4'd6;
  localparam logic [3:0] S_DIFF   = 4'd7;
  localparam logic [3:0] S_INTERP = 4'd8;
  localparam logic [3:0] S_ROUND  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // Configuration registers
  logic [PHASE_W-1:0] phase_inc_r;
  logic [WAVE_W-1:0]  wave_type_r;
  logic [TLEN_W-1:0]  table_len_r;

  // Control state
  logic [3:0]         state_r;
  logic [3:0]         state_nxt;
  logic               active_r;
  logic [PHASE_W-1:0] phase_r;
  logic               adv_r;
  logic               out_valid_r;

  // Datapath registers
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [P_W-1:0]      prod_r;
  logic [RW-1:0]              r_r;
  logic [1:0]                 quad_r;
  logic [N_W-1:0]             i0_r;
  logic [N_W-1:0]             i1_r;
  logic [15:0]                f_r;
  logic signed [SAMPLE_W-1:0] w0_r;
  logic signed [SAMPLE_W:0]   diff_r;
  logic [14:0]                rom_q;

  // Quarter-wave sine ROM, fixed at elaboration
  logic [14:0] sine_rom_w [QUARTER + 1];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    localparam logic [63:0] XK = (HALF_PI_Q30 * 64'(k)) / QUARTER;
    assign sine_rom_w[k] = sine_q15(XK);
  end

  // Handshake
  logic in_accept;
  logic out_free;
  assign in_accept = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Effective table length, saturated to the table depth
  logic [N_W-1:0] n_w;
  assign n_w = (32'(table_len_r) > 32'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH) : N_W'(table_len_r);

  // Square, sawtooth and triangle straight from the phase
  logic signed [17:0]         tri_hi_w;
  logic signed [SAMPLE_W-1:0] simple_w;
  assign tri_hi_w = 18'sd98304 - $signed({1'b0, phase_r[31:15]});
  always_comb begin
    case (wave_type_r)
      WAVE_SQUARE:   simple_w = phase_r[31] ? 16'sh8000 : 16'sh7FFF;
      WAVE_SAWTOOTH: simple_w = {~phase_r[31], phase_r[30:16]};
      WAVE_TRIANGLE: begin
        if (!phase_r[31]) begin
          simple_w = {~phase_r[30], phase_r[29:15]};
        end else if (tri_hi_w > 18'sd32767) begin
          simple_w = 16'sh7FFF;
        end else begin
          simple_w = tri_hi_w[15:0];
        end
      end
      default:       simple_w = '0;
    endcase
  end

  // Shared multiplier operands
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  always_comb begin
    if (state_r == S_INTERP) begin
      mul_a = {{(MA_W - SAMPLE_W - 1){diff_r[SAMPLE_W]}}, diff_r};
      mul_b = $signed(MB_W'(f_r));
    end else if (wave_type_r == WAVE_SINE) begin
      mul_a = $signed({1'b0, phase_r});
      mul_b = $signed(MB_W'(4 * QUARTER));
    end else begin
      mul_a = $signed({1'b0, phase_r});
      mul_b = $signed(MB_W'(n_w));
    end
  end

  // Table indexes from the scaled phase
  logic [IW-1:0]  idx_w;
  logic [N_W-1:0] i0_w;
  logic [N_W:0]   i0_inc_w;
  logic [N_W-1:0] i1_w;
  assign idx_w    = prod_r[P_W-1:PHASE_W];
  assign i0_w     = (idx_w >= IW'(n_w)) ? (n_w - N_W'(1)) : N_W'(idx_w);
  assign i0_inc_w = {1'b0, i0_w} + (N_W + 1)'(1);
  assign i1_w     = (i0_inc_w == {1'b0, n_w}) ? '0 : i0_inc_w[N_W-1:0];

  // Rounded interpolation
  logic signed [33:0] acc_w;
  assign acc_w = ($signed(34'(w0_r)) <<< 16) + $signed(prod_r[33:0]) + 34'sd32768;

  // Sine ROM address, mirrored on odd quadrants
  logic [S_W-1:0] rom_addr_w;
  assign rom_addr_w = quad_r[0] ? (S_W'(QUARTER) - S_W'(r_r)) : S_W'(r_r);

  // Wavetable RAM
  logic                ram_we;
  logic [TA_W-1:0]     ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  assign ram_we    = in_accept && (in_command == CMD_WRITE)
                     && (32'(in_table_index) < 32'(TABLE_DEPTH));
  assign ram_raddr = (state_r == S_RD0) ? TA_W'(i0_r) : TA_W'(i1_r);

  mwpo_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (TA_W'(in_table_index)),
    .wdata (in_table_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_command == CMD_TICK)) begin
          if (active_r && (wave_type_r == WAVE_SINE)) begin
            state_nxt = S_MUL;
          end else if (active_r && (wave_type_r == WAVE_CUSTOM) && (n_w != '0)) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL:    state_nxt = S_POS;
      S_POS:    state_nxt = (wave_type_r == WAVE_SINE) ? S_QUAD : S_RD0;
      S_QUAD:   state_nxt = (r_r >= RW'(QUARTER)) ? S_QUAD : S_ROM;
      S_ROM:    state_nxt = S_OUT;
      S_RD0:    state_nxt = S_RD1;
      S_RD1:    state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_ROUND;
      S_ROUND:  state_nxt = S_OUT;
      S_OUT:    state_nxt = out_free ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      phase_r     <= '0;
      adv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      phase_inc_r <= PHASE_INC_RST;
      wave_type_r <= WAVE_SINE;
      table_len_r <= '0;
    end else begin
      state_r <= state_nxt;
      // take configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_INC: phase_inc_r <= cfg_wdata;
          REG_WAVE_TYPE: wave_type_r <= cfg_wdata[WAVE_W-1:0];
          REG_TABLE_LEN: table_len_r <= cfg_wdata[TLEN_W-1:0];
          default:       ;
        endcase
      end
      // start, stop and tick bookkeeping
      if (in_accept) begin
        case (in_command)
          CMD_START: begin
            phase_r  <= '0;
            active_r <= 1'b1;
          end
          CMD_STOP:  active_r <= 1'b0;
          CMD_TICK:  adv_r <= active_r;
          default:   ;
        endcase
      end
      // hand the sample over and advance the phase
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        if (adv_r) begin
          phase_r <= phase_r + phase_inc_r;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rom_q <= sine_rom_w[rom_addr_w];
    if ((state_r == S_OUT) && out_free) begin
      out_sample_r <= sample_r;
    end
    case (state_r)
      S_IDLE: begin
        // simple waves, or zero when inactive or the table is empty
        sample_r <= active_r ? simple_w : '0;
      end
      S_MUL:    prod_r <= mul_a * mul_b;
      S_POS: begin
        r_r    <= RW'(idx_w);
        quad_r <= '0;
        i0_r   <= i0_w;
        i1_r   <= i1_w;
        f_r    <= prod_r[31:16];
      end
      S_QUAD: begin
        // peel off one quarter per cycle
        if (r_r >= RW'(QUARTER)) begin
          r_r    <= r_r - RW'(QUARTER);
          quad_r <= quad_r + 2'd1;
        end
      end
      S_ROM: begin
        sample_r <= quad_r[1] ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
      end
      S_RD1:    w0_r <= ram_rdata;
      S_DIFF:   diff_r <= $signed({ram_rdata[SAMPLE_W-1], ram_rdata})
                          - $signed({w0_r[SAMPLE_W-1], w0_r});
      S_INTERP: prod_r <= mul_a * mul_b;
      S_ROUND:  sample_r <= acc_w[31:16];
      default:  ;
    endcase
  end

endmodule

@@ hdl/mwpo_checker.sv @@
// ----------------------------------------------------------------------------
// mwpo_checker
// Port-level checks on the oscillator, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_waveform_phase_oscillator_assert.svh"

module mwpo_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [mwpo_pkg::CMD_W-1:0]           in_command,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [mwpo_pkg::SAMPLE_W-1:0] out_sample
);

  import mwpo_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // A held result stays offered
  `MWPO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

  // A held result keeps its value
  `MWPO_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_sample), "stalled sample changed")

  // Start, stop and table writes leave the input ready
  `MWPO_ASSERT_NEXT(a_ctl_ready, clk, rst_n, in_beat && (in_command != CMD_TICK), !in_stall, "control beat left input busy")

  // A tick always occupies the sequencer
  `MWPO_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_beat && (in_command == CMD_TICK), in_stall, "tick beat did not occupy sequencer")

endmodule

bind multi_waveform_phase_oscillator mwpo_checker u_mwpo_checker (.*);
